// ----- rtl/tlbpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared types and constants of the TLB and page table address translator.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbpt_pkg;

   // Default geometry
   localparam int DEF_TLB_ENTRIES = 16;
   localparam int DEF_PAGE_COUNT  = 256;
   localparam int DEF_FRAME_COUNT = 256;
   localparam int DEF_OFFSET_BITS = 8;

   // Fixed field widths of the channels
   localparam int ADDR_WIDTH      = 16;
   localparam int FRAME_IDX_WIDTH = 8;
   localparam int COUNT_WIDTH     = 16;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } tlbpt_state_type;

endpackage : tlbpt_pkg

`default_nettype wire

// ----- rtl/tlbpt_req_if.sv -----
// ----------------------------------------------------------------------------
// tlbpt_req_if
// Request channel: one logical address per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlbpt_req_if;
   import tlbpt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ADDR_WIDTH-1:0] vaddr;

   modport source (output valid, output vaddr, input ready);
   modport sink   (input valid, input vaddr, output ready);

endinterface : tlbpt_req_if

`default_nettype wire

// ----- rtl/tlbpt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tlbpt_rsp_if
// Response channel: translated address, flags and running totals.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlbpt_rsp_if;
   import tlbpt_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ADDR_WIDTH-1:0]      physical_address;
   logic [FRAME_IDX_WIDTH-1:0] frame_index;
   logic                       tlb_hit;
   logic                       demand_fault;
   logic                       no_free_frame;
   logic [COUNT_WIDTH-1:0]     hit_total;
   logic [COUNT_WIDTH-1:0]     fault_total;

   modport source (output valid, output physical_address, output frame_index,
                   output tlb_hit, output demand_fault, output no_free_frame,
                   output hit_total, output fault_total, input ready);
   modport sink   (input valid, input physical_address, input frame_index,
                   input tlb_hit, input demand_fault, input no_free_frame,
                   input hit_total, input fault_total, output ready);

endinterface : tlbpt_rsp_if

`default_nettype wire

// ----- rtl/tlb_page_table_translator_top.sv -----
// ----------------------------------------------------------------------------
// tlb_page_table_translator_top
// Address translator: fully associative TLB kept in age order, backed by a
// direct-indexed page table in a synchronous RAM with demand frame assignment.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+------------------------------------------
//   req_bus | in  | valid/ready | vaddr
//   rsp_bus | out | valid/ready | physical_address, frame_index, flags, totals
//
// Each address is taken in ST_IDLE, where the transfer issues the page table
// read; in ST_LOOKUP the registered read data and the TLB are resolved, state
// is updated and the output register is loaded.
// After reset the page table is cleared, one entry per cycle, through all
// PAGE_COUNT entries; no request is taken meanwhile. A stalled response holds the
// resolve step; the next request is still taken while a response waits.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_page_table_translator_top #(
   parameter int TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES,
   parameter int PAGE_COUNT  = tlbpt_pkg::DEF_PAGE_COUNT,
   parameter int FRAME_COUNT = tlbpt_pkg::DEF_FRAME_COUNT,
   parameter int OFFSET_BITS = tlbpt_pkg::DEF_OFFSET_BITS
) (
   input  wire          clock,
   input  wire          reset,
   tlbpt_req_if.sink    req_bus,
   tlbpt_rsp_if.source  rsp_bus
);
   import tlbpt_pkg::*;

   localparam int TLB_IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int FILL_W     = $clog2(TLB_ENTRIES + 1);
   localparam int PAGE_BITS  = $clog2(PAGE_COUNT);
   localparam int FRAME_BITS = $clog2(FRAME_COUNT);
   localparam int FREE_W     = FRAME_BITS + 1;
   localparam logic [31:0] OFF_MASK = 32'((64'd1 << OFFSET_BITS) - 64'd1);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   tlbpt_state_type state_ff, state_in;
   logic [PAGE_BITS-1:0]  clr_ff, clr_in;
   logic [ADDR_WIDTH-1:0] addr_ff;

   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [PAGE_BITS-1:0]  tag_ff [TLB_ENTRIES];
   logic [PAGE_BITS-1:0]  tag_in [TLB_ENTRIES];
   logic [FRAME_BITS-1:0] frm_ff [TLB_ENTRIES];
   logic [FRAME_BITS-1:0] frm_in [TLB_ENTRIES];

   logic [FREE_W-1:0]      next_free_ff, next_free_in;
   logic [COUNT_WIDTH-1:0] hit_cnt_ff, hit_cnt_in;
   logic [COUNT_WIDTH-1:0] fault_cnt_ff, fault_cnt_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ADDR_WIDTH-1:0]      rsp_phys_ff;
   logic [FRAME_IDX_WIDTH-1:0] rsp_frame_ff;
   logic                       rsp_hit_ff, rsp_fault_ff, rsp_none_ff;

   // Page table RAM: valid bit on top of the frame number
   logic [FRAME_BITS:0]  map_mem [PAGE_COUNT];
   logic [FRAME_BITS:0]  map_rd_ff;
   logic [PAGE_BITS-1:0] map_rd_addr;
   logic                 map_we;
   logic [PAGE_BITS-1:0] map_wr_addr;
   logic [FRAME_BITS:0]  map_wr_data;

   // ---------------------------------------------------------------------
   // Address split
   // ---------------------------------------------------------------------
   function automatic logic [PAGE_BITS-1:0] page_of(input logic [ADDR_WIDTH-1:0] a);
      logic [31:0] wide;
      wide = 32'(a) >> OFFSET_BITS;
      return wide[PAGE_BITS-1:0];
   endfunction

   logic [PAGE_BITS-1:0] page;
   assign page = page_of(addr_ff);

   // ---------------------------------------------------------------------
   // Control outputs
   // ---------------------------------------------------------------------
   logic accept, commit;

   always_comb begin
      req_bus.ready = 1'b0;
      commit        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         ST_LOOKUP: begin
            commit = !rsp_valid_ff || rsp_bus.ready;
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   assign accept = req_bus.valid && req_bus.ready;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == PAGE_BITS'(PAGE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // TLB search
   // ---------------------------------------------------------------------
   logic                 hit;
   logic [TLB_IDX_W-1:0] hit_idx;

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
         if ((FILL_W'(k) < fill_ff) && (tag_ff[k] == page)) begin
            hit     = 1'b1;
            hit_idx = TLB_IDX_W'(k);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Resolve: frame selection, counters, TLB reorder
   // ---------------------------------------------------------------------
   logic                  map_valid, fault, exhausted, tlb_full;
   logic [FRAME_BITS-1:0] frame;
   logic [FILL_W-1:0]     wpos;
   logic [31:0]           phys_wide;
   logic [31:0]           frame_wide;

   assign map_valid = map_rd_ff[FRAME_BITS];
   assign tlb_full  = (fill_ff == FILL_W'(TLB_ENTRIES));

   always_comb begin
      fault     = 1'b0;
      exhausted = 1'b0;
      frame     = '0;
      if (hit) begin
         frame = frm_ff[hit_idx];
      end else if (map_valid) begin
         frame = map_rd_ff[FRAME_BITS-1:0];
      end else if (next_free_ff < FREE_W'(FRAME_COUNT)) begin
         frame = next_free_ff[FRAME_BITS-1:0];
         fault = 1'b1;
      end else begin
         exhausted = 1'b1;
      end
   end

   assign frame_wide = 32'(frame);
   assign phys_wide  = (frame_wide << OFFSET_BITS) | (32'(addr_ff) & OFF_MASK);

   // Slot of the newest entry after the update
   always_comb begin
      if (hit) begin
         wpos = fill_ff - 1'b1;
      end else if (tlb_full) begin
         wpos = FILL_W'(TLB_ENTRIES - 1);
      end else begin
         wpos = fill_ff;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      for (int k = 0; k < TLB_ENTRIES; k++) begin
         tag_in[k] = tag_ff[k];
         frm_in[k] = frm_ff[k];
      end
      if (commit && !exhausted) begin
         if (!hit && !tlb_full) begin
            fill_in = fill_ff + 1'b1;
         end
         for (int k = 0; k < TLB_ENTRIES; k++) begin
            if (FILL_W'(k) == wpos) begin
               tag_in[k] = page;
               frm_in[k] = frame;
            end else if (k < TLB_ENTRIES - 1) begin
               // advance younger entries over the removed one
               if ((FILL_W'(k) < wpos) &&
                   ((!hit && tlb_full) || (hit && (TLB_IDX_W'(k) >= hit_idx)))) begin
                  tag_in[k] = tag_ff[k + 1];
                  frm_in[k] = frm_ff[k + 1];
               end
            end
         end
      end
   end

   always_comb begin
      next_free_in = next_free_ff;
      hit_cnt_in   = hit_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      if (commit) begin
         if (hit && (hit_cnt_ff != COUNT_MAX)) begin
            hit_cnt_in = hit_cnt_ff + 1'b1;
         end
         if (fault) begin
            next_free_in = next_free_ff + 1'b1;
            if (fault_cnt_ff != COUNT_MAX) begin
               fault_cnt_in = fault_cnt_ff + 1'b1;
            end
         end
      end
   end

   assign rsp_valid_in = commit ? 1'b1 : (rsp_valid_ff && !rsp_bus.ready);

   // ---------------------------------------------------------------------
   // Page table RAM ports
   // ---------------------------------------------------------------------
   assign map_rd_addr = accept ? page_of(req_bus.vaddr) : page;

   always_comb begin
      map_we      = 1'b0;
      map_wr_addr = page;
      map_wr_data = {1'b1, next_free_ff[FRAME_BITS-1:0]};
      if (state_ff == ST_CLEAR) begin
         map_we      = 1'b1;
         map_wr_addr = clr_ff;
         map_wr_data = '0;
      end else if (commit && fault) begin
         map_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_wr_addr] <= map_wr_data;
      end
      map_rd_ff <= map_mem[map_rd_addr];
   end

   // ---------------------------------------------------------------------
   // Register update
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         fill_ff      <= '0;
         next_free_ff <= '0;
         hit_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fill_ff      <= fill_in;
         next_free_ff <= next_free_in;
         hit_cnt_ff   <= hit_cnt_in;
         fault_cnt_ff <= fault_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= req_bus.vaddr;
      end
      for (int k = 0; k < TLB_ENTRIES; k++) begin
         tag_ff[k] <= tag_in[k];
         frm_ff[k] <= frm_in[k];
      end
      if (commit) begin
         rsp_phys_ff  <= exhausted ? '0 : phys_wide[ADDR_WIDTH-1:0];
         rsp_frame_ff <= exhausted ? '0 : frame_wide[FRAME_IDX_WIDTH-1:0];
         rsp_hit_ff   <= hit;
         rsp_fault_ff <= fault;
         rsp_none_ff  <= exhausted;
      end
   end

   // ---------------------------------------------------------------------
   // Response port
   // ---------------------------------------------------------------------
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.physical_address = rsp_phys_ff;
   assign rsp_bus.frame_index      = rsp_frame_ff;
   assign rsp_bus.tlb_hit          = rsp_hit_ff;
   assign rsp_bus.demand_fault     = rsp_fault_ff;
   assign rsp_bus.no_free_frame    = rsp_none_ff;
   assign rsp_bus.hit_total        = hit_cnt_ff;
   assign rsp_bus.fault_total      = fault_cnt_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(TLB_ENTRIES))
      else $error("TLB fill count beyond capacity");

   a_free_bound : assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= FREE_W'(FRAME_COUNT))
      else $error("free frame pointer beyond frame count");

   a_flags_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.tlb_hit && rsp_bus.demand_fault) &&
                        !(rsp_bus.demand_fault && rsp_bus.no_free_frame) &&
                        !(rsp_bus.tlb_hit && rsp_bus.no_free_frame))
      else $error("conflicting translation flags");

   a_no_clobber : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> rsp_valid_ff && $stable(rsp_phys_ff))
      else $error("pending response overwritten");

endmodule : tlb_page_table_translator_top

`default_nettype wire
